// ===== rtl/core/two_mode_secular_eval_assert.svh =====
// Assertion macros for the checker file of the two-mode secular evaluator.
// Depends on nothing; included by the checker module.
`ifndef TWO_MODE_SECULAR_EVAL_ASSERT_SVH
`define TWO_MODE_SECULAR_EVAL_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TMSE_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define TMSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TMSE_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tmse_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table of the secular evaluator.
// Depends on nothing; used by every module of the block.
package tmse_pkg;

    localparam int PHASE_W     = 32;
    localparam int CORDIC_W    = 34;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_ONE = 3'd0,
        CFG_RATIO_TWO = 3'd1,
        CFG_RATE_ONE  = 3'd2,
        CFG_RATE_TWO  = 3'd3,
        CFG_AMP_X_ONE = 3'd4,
        CFG_AMP_Y_ONE = 3'd5,
        CFG_AMP_X_TWO = 3'd6,
        CFG_AMP_Y_TWO = 3'd7
    } t_cfg_reg;

    // Folded phase of both modes: residual angle and the half-turn flag.
    typedef struct packed {
        logic               flip_one;
        logic [PHASE_W-1:0] z_one;
        logic               flip_two;
        logic [PHASE_W-1:0] z_two;
    } t_phase_word;

    function automatic logic [PHASE_W-1:0] atan_turn(input logic [4:0] k);
        logic [PHASE_W-1:0] v;
        unique case (k)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/two_mode_secular_eval.sv =====
// Top level of the two-mode secular evaluator: configuration registers and pipeline.
// Depends on tmse_pkg, tmse_front, tmse_queue, tmse_cordic and tmse_combine.
//
// Evaluates a two-mode secular solution for each time word. Each mode phase is the
// low 32 bits of rate times time; a pipelined CORDIC gives its cosine and sine, which
// weight the mode amplitudes, and the eigenvector ratios then scale the mode terms
// into the inner body components while the plain sums give the outer body. The block
// takes one word per clock cycle and delivers one result word per clock cycle when
// the output side does not stall. Between acceptance and offer a time word passes, in
// order, the phase product registers written at the accepting edge, the four-entry
// queue, the CORDIC micro-rotation stages and the multiply, round and saturate stages.
// The front end keeps accepting words while the evaluation pipeline is held, until the
// queue fills. Configuration registers are written through a plain write port and
// must only change while the block is idle.
module two_mode_secular_eval #(
    parameter int DATA_BITS     = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [31:0]                           i_time_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [DATA_BITS-1:0]           o_inner_x,
    output logic signed [DATA_BITS-1:0]           o_inner_y,
    output logic signed [DATA_BITS-1:0]           o_outer_x,
    output logic signed [DATA_BITS-1:0]           o_outer_y,
    input  logic                                  i_cfg_we,
    input  logic [tmse_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [((DATA_BITS > 32) ? DATA_BITS : 32)-1:0] i_cfg_wdata
);

    // Valid bits for the CORDIC stages plus the six combine stages.
    localparam int LAT = CORDIC_STAGES + 6;

    logic signed [DATA_BITS-1:0] r_ratio_one, r_ratio_two;
    logic [31:0]                 r_rate_one, r_rate_two;
    logic signed [DATA_BITS-1:0] r_amp_x_one, r_amp_y_one, r_amp_x_two, r_amp_y_two;
    logic [LAT-1:0]              r_vld;

    tmse_pkg::t_phase_word w_push_word;
    tmse_pkg::t_phase_word w_head_word;
    logic w_push, w_full, w_empty, w_pop, w_en;
    logic signed [tmse_pkg::CORDIC_W-1:0] w_cos_one, w_sin_one, w_cos_two, w_sin_two;

    // Configuration writes land directly in the working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_one <= '0;
            r_ratio_two <= '0;
            r_rate_one  <= '0;
            r_rate_two  <= '0;
            r_amp_x_one <= '0;
            r_amp_y_one <= '0;
            r_amp_x_two <= '0;
            r_amp_y_two <= '0;
        end else if (i_cfg_we) begin
            unique case (tmse_pkg::t_cfg_reg'(i_cfg_index))
                tmse_pkg::CFG_RATIO_ONE: r_ratio_one <= i_cfg_wdata[DATA_BITS-1:0];
                tmse_pkg::CFG_RATIO_TWO: r_ratio_two <= i_cfg_wdata[DATA_BITS-1:0];
                tmse_pkg::CFG_RATE_ONE:  r_rate_one  <= i_cfg_wdata[31:0];
                tmse_pkg::CFG_RATE_TWO:  r_rate_two  <= i_cfg_wdata[31:0];
                tmse_pkg::CFG_AMP_X_ONE: r_amp_x_one <= i_cfg_wdata[DATA_BITS-1:0];
                tmse_pkg::CFG_AMP_Y_ONE: r_amp_y_one <= i_cfg_wdata[DATA_BITS-1:0];
                tmse_pkg::CFG_AMP_X_TWO: r_amp_x_two <= i_cfg_wdata[DATA_BITS-1:0];
                tmse_pkg::CFG_AMP_Y_TWO: r_amp_y_two <= i_cfg_wdata[DATA_BITS-1:0];
                default: ;
            endcase
        end
    end

    tmse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_time_value (i_time_value),
        .i_rate_one   (r_rate_one),
        .i_rate_two   (r_rate_two),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_word       (w_push_word)
    );

    tmse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_word  (w_head_word)
    );

    // The whole evaluation pipeline moves unless a finished word is held at the output.
    // Empty slots travel as bubbles, so a held output never loses a word.
    assign w_en  = !(o_out_valid && i_out_stall);
    assign w_pop = w_en && !w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], !w_empty};
        end
    end

    assign o_out_valid = r_vld[LAT-1];

    tmse_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_one (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_flip (w_head_word.flip_one),
        .i_z    (w_head_word.z_one),
        .o_cos  (w_cos_one),
        .o_sin  (w_sin_one)
    );

    tmse_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_two (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_flip (w_head_word.flip_two),
        .i_z    (w_head_word.z_two),
        .o_cos  (w_cos_two),
        .o_sin  (w_sin_two)
    );

    tmse_combine #(.DATA_BITS(DATA_BITS)) u_combine (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_cos_one   (w_cos_one),
        .i_sin_one   (w_sin_one),
        .i_cos_two   (w_cos_two),
        .i_sin_two   (w_sin_two),
        .i_amp_x_one (r_amp_x_one),
        .i_amp_y_one (r_amp_y_one),
        .i_amp_x_two (r_amp_x_two),
        .i_amp_y_two (r_amp_y_two),
        .i_ratio_one (r_ratio_one),
        .i_ratio_two (r_ratio_two),
        .o_inner_x   (o_inner_x),
        .o_inner_y   (o_inner_y),
        .o_outer_x   (o_outer_x),
        .o_outer_y   (o_outer_y)
    );

endmodule

// ===== rtl/core/tmse_front.sv =====
// Front end: accepts time words, forms both mode phases and folds their quadrants.
// Depends on tmse_pkg; feeds tmse_queue.
module tmse_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [31:0]                i_time_value,
    input  logic [31:0]                i_rate_one,
    input  logic [31:0]                i_rate_two,
    input  logic                       i_full,
    output logic                       o_push,
    output tmse_pkg::t_phase_word      o_word
);

    logic        r_valid;
    logic [31:0] r_ph_one;
    logic [31:0] r_ph_two;
    logic        w_adv;
    logic        w_flip_one;
    logic        w_flip_two;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign w_adv   = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    // Only the low 32 bits of the product matter: the phase wraps each turn.
    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_ph_one <= 32'(i_rate_one * i_time_value);
            r_ph_two <= 32'(i_rate_two * i_time_value);
        end
    end

    // Phases in the second and third quarter turn move by half a turn.
    assign w_flip_one = r_ph_one[31] ^ r_ph_one[30];
    assign w_flip_two = r_ph_two[31] ^ r_ph_two[30];

    always_comb begin
        o_word.flip_one = w_flip_one;
        o_word.z_one    = {r_ph_one[31] ^ w_flip_one, r_ph_one[30:0]};
        o_word.flip_two = w_flip_two;
        o_word.z_two    = {r_ph_two[31] ^ w_flip_two, r_ph_two[30:0]};
    end

endmodule

// ===== rtl/core/tmse_queue.sv =====
// Short queue that parts the front end from the evaluation pipeline.
// Depends on tmse_pkg.
module tmse_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tmse_pkg::t_phase_word i_word,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output tmse_pkg::t_phase_word o_word
);

    tmse_pkg::t_phase_word r_mem [tmse_pkg::QUEUE_DEPTH];
    logic [tmse_pkg::QUEUE_PTR_W-1:0] r_wr;
    logic [tmse_pkg::QUEUE_PTR_W-1:0] r_rd;
    logic [tmse_pkg::QUEUE_CNT_W-1:0] r_cnt;
    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == tmse_pkg::QUEUE_CNT_W'(tmse_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

// ===== rtl/core/tmse_cordic.sv =====
// Pipelined rotation-mode CORDIC, one register stage per micro-rotation.
// Depends on tmse_pkg for the gain and the arctangent table.
module tmse_cordic #(
    parameter int STAGES = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic                                    i_flip,
    input  logic [tmse_pkg::PHASE_W-1:0]            i_z,
    output logic signed [tmse_pkg::CORDIC_W-1:0]    o_cos,
    output logic signed [tmse_pkg::CORDIC_W-1:0]    o_sin
);

    localparam int W = tmse_pkg::CORDIC_W;

    logic signed [W-1:0] r_x [STAGES];
    logic signed [W-1:0] r_y [STAGES];
    logic signed [W-1:0] r_z [STAGES];
    logic                r_flip [STAGES];

    genvar g;
    for (g = 0; g < STAGES; g++) begin : g_stage
        logic signed [W-1:0] x_in;
        logic signed [W-1:0] y_in;
        logic signed [W-1:0] z_in;
        logic                flip_in;
        logic signed [W-1:0] atan_v;

        if (g == 0) begin : g_first
            assign x_in    = tmse_pkg::GAIN_Q30;
            assign y_in    = '0;
            assign z_in    = W'(signed'(i_z));
            assign flip_in = i_flip;
        end else begin : g_next
            assign x_in    = r_x[g-1];
            assign y_in    = r_y[g-1];
            assign z_in    = r_z[g-1];
            assign flip_in = r_flip[g-1];
        end

        assign atan_v = W'(tmse_pkg::atan_turn(5'(g)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[g] <= flip_in;
                if (!z_in[W-1]) begin
                    r_x[g] <= x_in - (y_in >>> g);
                    r_y[g] <= y_in + (x_in >>> g);
                    r_z[g] <= z_in - atan_v;
                end else begin
                    r_x[g] <= x_in + (y_in >>> g);
                    r_y[g] <= y_in - (x_in >>> g);
                    r_z[g] <= z_in + atan_v;
                end
            end
        end
    end

    assign o_cos = r_flip[STAGES-1] ? -r_x[STAGES-1] : r_x[STAGES-1];
    assign o_sin = r_flip[STAGES-1] ? -r_y[STAGES-1] : r_y[STAGES-1];

endmodule

// ===== rtl/core/tmse_combine.sv =====
// Weights cosine and sine by the amplitudes, then by the eigenvector ratios.
// Depends on tmse_pkg; six register stages advanced together by i_en.
module tmse_combine #(
    parameter int DATA_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [tmse_pkg::CORDIC_W-1:0] i_cos_one,
    input  logic signed [tmse_pkg::CORDIC_W-1:0] i_sin_one,
    input  logic signed [tmse_pkg::CORDIC_W-1:0] i_cos_two,
    input  logic signed [tmse_pkg::CORDIC_W-1:0] i_sin_two,
    input  logic signed [DATA_BITS-1:0]          i_amp_x_one,
    input  logic signed [DATA_BITS-1:0]          i_amp_y_one,
    input  logic signed [DATA_BITS-1:0]          i_amp_x_two,
    input  logic signed [DATA_BITS-1:0]          i_amp_y_two,
    input  logic signed [DATA_BITS-1:0]          i_ratio_one,
    input  logic signed [DATA_BITS-1:0]          i_ratio_two,
    output logic signed [DATA_BITS-1:0]          o_inner_x,
    output logic signed [DATA_BITS-1:0]          o_inner_y,
    output logic signed [DATA_BITS-1:0]          o_outer_x,
    output logic signed [DATA_BITS-1:0]          o_outer_y
);

    localparam int D  = DATA_BITS;
    localparam int PW = D + tmse_pkg::CORDIC_W;
    localparam int RW = D + 2;
    localparam int QW = 2 * D;
    localparam int FW = D + 4;
    localparam int SW = D + 6;
    localparam int FR = D - 4;
    localparam logic signed [D-1:0] MAX_D = {1'b0, {(D-1){1'b1}}};
    localparam logic signed [D-1:0] MIN_D = {1'b1, {(D-1){1'b0}}};

    logic signed [PW-1:0] r_p [8];
    logic signed [RW-1:0] r_r [8];
    logic signed [D-1:0]  r_mx_one, r_my_one, r_mx_two, r_my_two;
    logic signed [QW-1:0] r_q [4];
    logic signed [D-1:0]  r_ox_a, r_oy_a, r_ox_b, r_oy_b;
    logic signed [FW-1:0] r_f [4];

    // Magnitude rounding: nearest, ties away from zero.
    function automatic logic signed [RW-1:0] rnd_mode(input logic signed [PW-1:0] p);
        logic [PW-1:0] m;
        logic [PW-1:0] q;
        m = p[PW-1] ? PW'(-p) : PW'(p);
        q = (m + (PW'(1) << 29)) >> 30;
        return p[PW-1] ? RW'(-q) : RW'(q);
    endfunction

    function automatic logic signed [FW-1:0] rnd_ratio(input logic signed [QW-1:0] p);
        logic [QW-1:0] m;
        logic [QW-1:0] q;
        m = p[QW-1] ? QW'(-p) : QW'(p);
        q = (m + (QW'(1) << (FR - 1))) >> FR;
        return p[QW-1] ? FW'(-q) : FW'(q);
    endfunction

    function automatic logic signed [D-1:0] sat_d(input logic signed [SW-1:0] v);
        logic signed [D-1:0] res;
        priority if (v > SW'(MAX_D)) begin
            res = MAX_D;
        end else if (v < SW'(MIN_D)) begin
            res = MIN_D;
        end else begin
            res = v[D-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_amp_x_one * i_cos_one;
            r_p[1] <= i_amp_y_one * i_sin_one;
            r_p[2] <= i_amp_x_one * i_sin_one;
            r_p[3] <= i_amp_y_one * i_cos_one;
            r_p[4] <= i_amp_x_two * i_cos_two;
            r_p[5] <= i_amp_y_two * i_sin_two;
            r_p[6] <= i_amp_x_two * i_sin_two;
            r_p[7] <= i_amp_y_two * i_cos_two;

            for (int k = 0; k < 8; k++) begin
                r_r[k] <= rnd_mode(r_p[k]);
            end

            r_mx_one <= sat_d(SW'(r_r[0]) + SW'(r_r[1]));
            r_my_one <= sat_d(SW'(r_r[2]) - SW'(r_r[3]));
            r_mx_two <= sat_d(SW'(r_r[4]) + SW'(r_r[5]));
            r_my_two <= sat_d(SW'(r_r[6]) - SW'(r_r[7]));

            r_q[0] <= i_ratio_one * r_mx_one;
            r_q[1] <= i_ratio_two * r_mx_two;
            r_q[2] <= i_ratio_one * r_my_one;
            r_q[3] <= i_ratio_two * r_my_two;
            r_ox_a <= sat_d(SW'(r_mx_one) + SW'(r_mx_two));
            r_oy_a <= sat_d(SW'(r_my_one) + SW'(r_my_two));

            for (int k = 0; k < 4; k++) begin
                r_f[k] <= rnd_ratio(r_q[k]);
            end
            r_ox_b <= r_ox_a;
            r_oy_b <= r_oy_a;

            o_inner_x <= sat_d(SW'(r_f[0]) + SW'(r_f[1]));
            o_inner_y <= sat_d(SW'(r_f[2]) + SW'(r_f[3]));
            o_outer_x <= r_ox_b;
            o_outer_y <= r_oy_b;
        end
    end

endmodule

// ===== rtl/core/tmse_checker.sv =====
// Port-level checks of the two-mode secular evaluator, bound to its top level.
// Depends on two_mode_secular_eval_assert.svh and two_mode_secular_eval.
`include "two_mode_secular_eval_assert.svh"

module tmse_checker #(
    parameter int DATA_BITS = 32
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic signed [DATA_BITS-1:0] o_inner_x,
    input logic signed [DATA_BITS-1:0] o_inner_y,
    input logic signed [DATA_BITS-1:0] o_outer_x,
    input logic signed [DATA_BITS-1:0] o_outer_y
);

    // A held result word stays offered.
    `TMSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result word dropped while stalled")

    // A held result word keeps its value.
    `TMSE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_inner_x) && $stable(o_inner_y) && $stable(o_outer_x) && $stable(o_outer_y), "result word changed while stalled")

    // The input side only backs up after the output side held a word.
    `TMSE_ASSERT_HOLD(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall), $past(o_out_valid && i_out_stall), "input stall without output backpressure")

    // Reset empties the pipeline and the queue.
    `TMSE_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "reset left a word in flight")

endmodule

bind two_mode_secular_eval tmse_checker #(.DATA_BITS(DATA_BITS)) u_tmse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_inner_x   (o_inner_x),
    .o_inner_y   (o_inner_y),
    .o_outer_x   (o_outer_x),
    .o_outer_y   (o_outer_y)
);

// ===== bench/tb_two_mode_secular_eval.sv =====
// Self-checking bench for the two-mode secular evaluator: directed words, then random ones.
// Depends on tmse_pkg and two_mode_secular_eval; results are checked against a local model.
`timescale 1ns / 100ps

module tb_two_mode_secular_eval;

    localparam int DATA_BITS     = 32;
    localparam int CORDIC_STAGES = 24;
    // The drain margin covers the pipeline from acceptance to result, with slack.
    localparam int DRAIN_CYCLES  = CORDIC_STAGES + 16;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int RANDOM_WORDS  = 1230;

    // Quadrant boundaries and a few odd times for the directed part.
    localparam logic [31:0] SPECIAL_TIMES [12] = '{
        32'h0000_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hBFFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF,
        32'h2000_0000, 32'hE000_0000, 32'h0000_0001, 32'h5555_5555
    };

    typedef struct packed {
        logic signed [DATA_BITS-1:0] inner_x;
        logic signed [DATA_BITS-1:0] inner_y;
        logic signed [DATA_BITS-1:0] outer_x;
        logic signed [DATA_BITS-1:0] outer_y;
    } t_ecc_word;

    // One row of the directed table. A typed row carries its expected word; the
    // other rows take theirs from the local model.
    typedef struct {
        logic [31:0] tv;
        bit          typed;
        t_ecc_word   ecc;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [31:0]                    i_time_value = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic signed [DATA_BITS-1:0]    o_inner_x;
    logic signed [DATA_BITS-1:0]    o_inner_y;
    logic signed [DATA_BITS-1:0]    o_outer_x;
    logic signed [DATA_BITS-1:0]    o_outer_y;
    logic                           i_cfg_we = 1'b0;
    logic [tmse_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                    i_cfg_wdata = '0;

    two_mode_secular_eval #(
        .DATA_BITS    (DATA_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_time_value(i_time_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_inner_x   (o_inner_x),
        .o_inner_y   (o_inner_y),
        .o_outer_x   (o_outer_x),
        .o_outer_y   (o_outer_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the register file, updated together with each write.
    logic [31:0] cfg_shadow [8];

    // Expected eccentricity words, oldest first.
    t_ecc_word   pending_ecc [$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Sender burst state and receiver hold-off request.
    int          burst_left = 0;
    bit          hold_request = 1'b0;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam longint ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0
    };
    localparam longint CORDIC_GAIN = 652032874;

    // Product scaled down by 2^sh, rounded to nearest with ties away from zero.
    function automatic longint scaled_product(longint a, longint b, int sh);
        logic         neg;
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] prod;
        longint       mag;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 128'(-a) : 128'(a);
        ub   = (b < 0) ? 128'(-b) : 128'(b);
        prod = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
        mag  = longint'({2'b00, prod[61:0]});
        return neg ? -mag : mag;
    endfunction

    function automatic longint clamp_data(longint v);
        longint lim;
        lim = longint'(1) <<< (DATA_BITS - 1);
        if (v > lim - 1) begin
            return lim - 1;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Cosine and sine in Q2.30 of a phase in 2^-32 turn. Phases in the middle
    // half turn are folded by half a turn and the results negated.
    task automatic phase_cos_sin(input logic [31:0] phase, output longint c,
                                 output longint s);
        logic        flip;
        logic [31:0] p;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
        p    = flip ? phase + 32'h8000_0000 : phase;
        z    = longint'($signed(p));
        x    = CORDIC_GAIN;
        y    = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> (i % 32);
            dy = x >>> (i % 32);
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i % 32];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i % 32];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Saturated x and y terms of one mode at one time.
    task automatic mode_term(input logic [31:0] rate, input logic [31:0] tv,
                             input logic [31:0] ax_reg, input logic [31:0] ay_reg,
                             output longint mx, output longint my);
        logic [63:0] phase_full;
        longint      c;
        longint      s;
        longint      ax;
        longint      ay;
        phase_full = 64'(rate) * 64'(tv);
        phase_cos_sin(phase_full[31:0], c, s);
        ax = longint'($signed(ax_reg));
        ay = longint'($signed(ay_reg));
        mx = clamp_data(scaled_product(ax, c, 30) + scaled_product(ay, s, 30));
        my = clamp_data(scaled_product(ax, s, 30) - scaled_product(ay, c, 30));
    endtask

    // Eccentricity of both bodies at one time under the current registers.
    task automatic eval_secular(input logic [31:0] tv, output t_ecc_word ecc);
        longint x1;
        longint y1;
        longint x2;
        longint y2;
        longint r1;
        longint r2;
        mode_term(cfg_shadow[tmse_pkg::CFG_RATE_ONE], tv, cfg_shadow[tmse_pkg::CFG_AMP_X_ONE],
                  cfg_shadow[tmse_pkg::CFG_AMP_Y_ONE], x1, y1);
        mode_term(cfg_shadow[tmse_pkg::CFG_RATE_TWO], tv, cfg_shadow[tmse_pkg::CFG_AMP_X_TWO],
                  cfg_shadow[tmse_pkg::CFG_AMP_Y_TWO], x2, y2);
        r1 = longint'($signed(cfg_shadow[tmse_pkg::CFG_RATIO_ONE]));
        r2 = longint'($signed(cfg_shadow[tmse_pkg::CFG_RATIO_TWO]));
        ecc.inner_x = DATA_BITS'(clamp_data(scaled_product(r1, x1, DATA_BITS - 4)
                                            + scaled_product(r2, x2, DATA_BITS - 4)));
        ecc.inner_y = DATA_BITS'(clamp_data(scaled_product(r1, y1, DATA_BITS - 4)
                                            + scaled_product(r2, y2, DATA_BITS - 4)));
        ecc.outer_x = DATA_BITS'(clamp_data(x1 + x2));
        ecc.outer_y = DATA_BITS'(clamp_data(y1 + y2));
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(input tmse_pkg::t_cfg_reg idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        cfg_shadow[idx] = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offers one time word and holds it until accepted. Gaps between words come
    // in bursts; a burst with no gap keeps valid high across words.
    task automatic send_time(input logic [31:0] tv, input bit typed,
                             input t_ecc_word typed_ecc);
        t_ecc_word ecc;
        int        gap;
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_time_value = tv;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                break;
            end
        end
        if (typed) begin
            ecc = typed_ecc;
        end else begin
            eval_secular(tv, ecc);
        end
        pending_ecc.push_back(ecc);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Lower valid, wait for every expected word, then let the pipeline settle.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_ecc.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_q428();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h1000_0000;
            4: return 32'hF000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h4000_0000;
            4: return 32'($urandom_range(1, 4096));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    // Receiver: stalls on its own pattern, picked anew at the end of each random span,
    // and on request holds off long enough for the queue to fill and stall input.
    initial begin : receiver_proc
        int mode;
        int span;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (300) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = ($urandom_range(0, 3) == 0);
                    2: i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ~i_out_stall;
                endcase
            end
        end
    end

    // Result check: every accepted result word is matched against the oldest
    // expected one, field by field.
    always @(posedge i_clk) begin
        t_ecc_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_ecc.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result word: %0d %0d %0d %0d",
                             o_inner_x, o_inner_y, o_outer_x, o_outer_y);
                end
            end else begin
                want = pending_ecc.pop_front();
                if (o_inner_x !== want.inner_x || o_inner_y !== want.inner_y ||
                    o_outer_x !== want.outer_x || o_outer_y !== want.outer_y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.inner_x, want.inner_y, want.outer_x, want.outer_y,
                                 o_inner_x, o_inner_y, o_outer_x, o_outer_y);
                    end
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus_proc
        t_stim_row rows [$];
        t_stim_row row;
        t_ecc_word zero_ecc;
        int        sent;
        int        phase_len;

        zero_ecc = '0;
        for (int i = 0; i < 8; i++) begin
            cfg_shadow[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. After reset every register is zero, so every result
        // is zero whatever the time.
        row.typed = 1'b1;
        row.ecc   = zero_ecc;
        row.tv = 32'h0000_0000;        rows.push_back(row);
        row.tv = 32'hFFFF_FFFF;        rows.push_back(row);
        row.tv = 32'h8000_0000;        rows.push_back(row);
        row.tv = 32'h0000_0001;        rows.push_back(row);
        // Quadrant boundaries with extreme amplitudes and ratios: the phase
        // equals the time for the first mode and its negation for the second,
        // and the mode and output sums can saturate.
        row.typed = 1'b0;
        for (int i = 0; i < 12; i++) begin
            row.tv = SPECIAL_TIMES[i];
            rows.push_back(row);
        end

        foreach (rows[i]) begin
            if (i == 4) begin
                drain_results();
                write_reg(tmse_pkg::CFG_RATIO_ONE, 32'h7FFF_FFFF);
                write_reg(tmse_pkg::CFG_RATIO_TWO, 32'h8000_0000);
                write_reg(tmse_pkg::CFG_RATE_ONE,  32'h0000_0001);
                write_reg(tmse_pkg::CFG_RATE_TWO,  32'hFFFF_FFFF);
                write_reg(tmse_pkg::CFG_AMP_X_ONE, 32'h7FFF_FFFF);
                write_reg(tmse_pkg::CFG_AMP_Y_ONE, 32'h7FFF_FFFF);
                write_reg(tmse_pkg::CFG_AMP_X_TWO, 32'h8000_0000);
                write_reg(tmse_pkg::CFG_AMP_Y_TWO, 32'h1000_0000);
            end
            send_time(rows[i].tv, rows[i].typed, rows[i].ecc);
        end
        drain_results();

        // Random part in phases, each under a fresh register setting. One phase
        // asks the receiver for a long hold-off while words keep coming.
        sent = 0;
        for (int ph = 0; sent < RANDOM_WORDS; ph++) begin
            for (int r = 0; r < 8; r++) begin
                if (r == tmse_pkg::CFG_RATE_ONE || r == tmse_pkg::CFG_RATE_TWO) begin
                    write_reg(tmse_pkg::t_cfg_reg'(r), pick_rate());
                end else begin
                    write_reg(tmse_pkg::t_cfg_reg'(r), pick_q428());
                end
            end
            if (ph == 2) begin
                hold_request = 1'b1;
                burst_left   = 200;
            end
            phase_len = $urandom_range(60, 160);
            for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
                send_time(pick_time(), 1'b0, zero_ecc);
                sent++;
            end
            drain_results();
        end

        if (mismatch_count == 0 && pending_ecc.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
